// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sinc series evaluator.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Field widths of the request and result items
  localparam int X_W        = 16;
  localparam int SUM_OUT_W  = 32;
  localparam int CNT_OUT_W  = 6;
  localparam int CNT_SAT_W  = 7;

  // Register widths and reset values
  localparam int ABS_ERR_W  = 31;
  localparam int MAX_TRM_W  = 6;
  localparam logic [ABS_ERR_W-1:0] ABS_ERROR_RST = 31'd1024;
  localparam logic [MAX_TRM_W-1:0] MAX_TERMS_RST = 6'd16;

  // Configuration bus
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // x^2 is kept exact with 30 fractional bits, at most 2^30
  localparam int XSQ_W      = 31;
  localparam int XSQ_FRAC   = 30;
  // Split point of the term magnitude for the x^2 product
  localparam int LO_W       = 20;
  // Width of one reciprocal division step
  localparam int DIV_DATA_W = 32;

  typedef enum logic {
    REG_ABS_ERROR = 1'b0,
    REG_MAX_TERMS = 1'b1
  } sts_reg_t;

  typedef struct packed {
    logic [ABS_ERR_W-1:0] abs_error;
    logic [MAX_TRM_W-1:0] max_terms;
  } sts_cfg_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } sts_ctrl_t;

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
  } sts_in_t;

  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] series_sum;
    logic [CNT_OUT_W-1:0]        terms_used;
    logic                        not_converged;
  } sts_out_t;

endpackage

// ===== src/sts_stream_if.sv =====
// ----------------------------------------------------------------------------
// sts_stream_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface sts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sts_cfg.sv =====
// ----------------------------------------------------------------------------
// sts_cfg
// APB register file holding the stop threshold and the term limit.
// ----------------------------------------------------------------------------
module sts_cfg
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sts_cfg_t              cfg_o
);

  sts_cfg_t cfg_r;
  sts_cfg_t cfg_nxt;
  sts_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = sts_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_ABS_ERROR: cfg_nxt.abs_error = pwdata[ABS_ERR_W-1:0];
        REG_MAX_TERMS: cfg_nxt.max_terms = pwdata[MAX_TRM_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.abs_error <= ABS_ERROR_RST;
      cfg_r.max_terms <= MAX_TERMS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ABS_ERROR: prdata = APB_DATA_W'(cfg_r.abs_error);
      REG_MAX_TERMS: prdata = APB_DATA_W'(cfg_r.max_terms);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

// ===== src/sts_cell.sv =====
// ----------------------------------------------------------------------------
// sts_cell
// One series term: multiply the last term by x^2, divide by i*(i+1) with a
// fixed reciprocal, and add the new term to or take it from the running sum.
// ----------------------------------------------------------------------------
module sts_cell
  import sts_pkg::*;
#(
  parameter int FRAC_BITS  = 30,
  parameter int TERM_LIMIT = 32,
  parameter int CELL_IDX   = 1,
  localparam int MAG_W     = FRAC_BITS + 1,
  localparam int SUM_W     = FRAC_BITS + 2,
  localparam int N_W       = $clog2(TERM_LIMIT + 1),
  localparam int ERR_W     = (FRAC_BITS >= 30) ? FRAC_BITS + 1 : ABS_ERR_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [ERR_W-1:0]        err_i,
  input  logic [N_W-1:0]          limit_i,
  input  sts_ctrl_t               ctrl_i,
  input  logic [N_W-1:0]          n_i,
  input  logic [MAG_W-1:0]        mag_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [XSQ_W-1:0]        xsq_i,
  output sts_ctrl_t               ctrl_o,
  output logic [N_W-1:0]          n_o,
  output logic [MAG_W-1:0]        mag_o,
  output logic signed [SUM_W-1:0] sum_o,
  output logic [XSQ_W-1:0]        xsq_o
);

  localparam int I_VAL  = 2 * CELL_IDX;
  localparam int DIV    = I_VAL * (I_VAL + 1);
  localparam int DIV_W  = $clog2(DIV + 1);
  localparam int DW     = DIV_DATA_W - DIV_W;
  localparam int NDIG   = (MAG_W <= DIV_DATA_W) ? 1 :
                          1 + (MAG_W - DIV_DATA_W + DW - 1) / DW;
  localparam int PW     = DIV_DATA_W + (NDIG - 1) * DW;
  localparam int NST    = 3 + 2 * NDIG;
  localparam int MX_W   = (MAG_W > LO_W + 1) ? MAG_W : LO_W + 1;
  localparam int HI_W   = MX_W - LO_W;
  localparam int PA_W   = HI_W + XSQ_W;
  localparam int PB_W   = LO_W + XSQ_W;
  localparam int LSH    = XSQ_FRAC - LO_W;
  localparam logic [DIV_DATA_W-1:0] RECIP =
    DIV_DATA_W'((64'd1 << DIV_DATA_W) / DIV);
  localparam logic [DIV_DATA_W:0] DIV_C = (DIV_DATA_W + 1)'(DIV);

  // Per-stage carry of the term state
  sts_ctrl_t               ctrl_r [NST];
  logic                    run_r  [NST-1];
  logic [N_W-1:0]          n_r    [NST];
  logic [MAG_W-1:0]        mag_r  [NST];
  logic signed [SUM_W-1:0] sum_r  [NST];
  logic [XSQ_W-1:0]        xsq_r  [NST];

  // Product and division datapath
  logic [PA_W-1:0]       pa_r;
  logic [PB_W-1:0]       pb_r;
  logic [PW-1:0]         p1_r;
  logic [DIV_DATA_W-1:0] vA_r    [NDIG];
  logic [DIV_DATA_W-1:0] q0A_r   [NDIG];
  logic [PW-1:0]         pA_r    [NDIG];
  logic [PW-1:0]         qaccA_r [NDIG];
  logic [DIV_W-1:0]      remB_r  [NDIG];
  logic [PW-1:0]         qaccB_r [NDIG];
  logic [PW-1:0]         pB_r    [NDIG];

  logic                    run_nxt;
  logic [MX_W-1:0]         mag_ext;
  logic [PA_W-1:0]         pa_nxt;
  logic [PB_W-1:0]         pb_nxt;
  logic [PB_W:0]           low_sum;
  logic [PA_W-1:0]         p_full;
  logic [PW-1:0]           p1_nxt;
  sts_ctrl_t               ctrl_fin_nxt;
  logic [N_W-1:0]          n_fin_nxt;
  logic [MAG_W-1:0]        mag_fin_nxt;
  logic signed [SUM_W-1:0] sum_fin_nxt;
  logic [MAG_W-1:0]        quot;

  // Stage 0: decide whether this term is taken, form the partial products
  always_comb begin
    run_nxt = ctrl_i.valid && (ERR_W'(mag_i) > err_i) && (n_i < limit_i);
    mag_ext = MX_W'(mag_i);
    pa_nxt  = PA_W'(mag_ext[MX_W-1:LO_W]) * PA_W'(xsq_i);
    pb_nxt  = PB_W'(mag_ext[LO_W-1:0]) * PB_W'(xsq_i);
  end

  // Stage 1: floor(mag * x^2 / 2^30)
  always_comb begin
    low_sum = (PB_W + 1)'({pa_r[LSH-1:0], LO_W'(0)}) + (PB_W + 1)'(pb_r);
    p_full  = (pa_r >> LSH) + PA_W'(low_sum >> XSQ_FRAC);
    p1_nxt  = PW'(p_full[MAG_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      p1_r <= p1_nxt;
    end
  end

  // Division by i*(i+1), one digit per pair of stages
  for (genvar j = 0; j < NDIG; j++) begin : g_dig
    logic [DIV_DATA_W-1:0] v_nxt;
    logic [PW-1:0]         p_src;
    logic [PW-1:0]         qacc_src;
    logic [63:0]           prod;
    logic [DIV_DATA_W:0]   diff;
    logic                  ge;
    logic [DIV_DATA_W-1:0] qd;
    logic [DIV_DATA_W:0]   rem_full;

    if (j == 0) begin : g_top
      assign p_src    = p1_r;
      assign v_nxt    = p1_r[PW-1 -: DIV_DATA_W];
      assign qacc_src = '0;
    end else begin : g_low
      assign p_src    = pB_r[j-1];
      assign v_nxt    = {remB_r[j-1], pB_r[j-1][PW-1-DIV_DATA_W-(j-1)*DW -: DW]};
      assign qacc_src = qaccB_r[j-1];
    end

    assign prod = 64'(v_nxt) * 64'(RECIP);

    // Estimate is low by at most one: correct with a single compare
    always_comb begin
      diff     = (DIV_DATA_W + 1)'(vA_r[j]) -
                 ((DIV_DATA_W + 1)'(q0A_r[j]) * DIV_C);
      ge       = (diff >= DIV_C);
      qd       = ge ? q0A_r[j] + 1'b1 : q0A_r[j];
      rem_full = ge ? diff - DIV_C : diff;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        vA_r[j]    <= v_nxt;
        q0A_r[j]   <= prod[63:DIV_DATA_W];
        pA_r[j]    <= p_src;
        qaccA_r[j] <= qacc_src;
        remB_r[j]  <= rem_full[DIV_W-1:0];
        qaccB_r[j] <= (qaccA_r[j] << DW) | PW'(qd);
        pB_r[j]    <= pA_r[j];
      end
    end
  end

  // Last stage: add or subtract the new term
  assign quot = qaccB_r[NDIG-1][MAG_W-1:0];

  always_comb begin
    ctrl_fin_nxt = ctrl_r[NST-2];
    n_fin_nxt    = n_r[NST-2];
    mag_fin_nxt  = mag_r[NST-2];
    sum_fin_nxt  = sum_r[NST-2];
    if (run_r[NST-2]) begin
      ctrl_fin_nxt.neg = !ctrl_r[NST-2].neg;
      mag_fin_nxt      = quot;
      n_fin_nxt        = n_r[NST-2] + 1'b1;
      if (ctrl_fin_nxt.neg) begin
        sum_fin_nxt = sum_r[NST-2] - signed'({1'b0, quot});
      end else begin
        sum_fin_nxt = sum_r[NST-2] + signed'({1'b0, quot});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        ctrl_r[s].valid <= 1'b0;
      end
    end else if (adv) begin
      ctrl_r[0] <= ctrl_i;
      for (int s = 1; s < NST - 1; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
      end
      ctrl_r[NST-1] <= ctrl_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      run_r[0] <= run_nxt;
      n_r[0]   <= n_i;
      mag_r[0] <= mag_i;
      sum_r[0] <= sum_i;
      xsq_r[0] <= xsq_i;
      for (int s = 1; s < NST - 1; s++) begin
        run_r[s] <= run_r[s-1];
        n_r[s]   <= n_r[s-1];
        mag_r[s] <= mag_r[s-1];
        sum_r[s] <= sum_r[s-1];
        xsq_r[s] <= xsq_r[s-1];
      end
      n_r[NST-1]   <= n_fin_nxt;
      mag_r[NST-1] <= mag_fin_nxt;
      sum_r[NST-1] <= sum_fin_nxt;
      xsq_r[NST-1] <= xsq_r[NST-2];
    end
  end

  assign ctrl_o = ctrl_r[NST-1];
  assign n_o    = n_r[NST-1];
  assign mag_o  = mag_r[NST-1];
  assign sum_o  = sum_r[NST-1];
  assign xsq_o  = xsq_r[NST-1];

endmodule

// ===== src/sinc_taylor_series.sv =====
// Division: one digit per cell while the term magnitude fits 32 bits
//   (FRAC_BITS <= 31).
// Throughput: one request per cycle; each term after the first has its own cell,
//   and the cell pipeline holds only when the result register is not taken.
// Reset: abs_error returns to 1024 and max_terms to 16; the chain is emptied.
// ----------------------------------------------------------------------------
// sinc_taylor_series
// sin(x)/x by its Maclaurin series over a chain of per-term cells.
// ----------------------------------------------------------------------------
module sinc_taylor_series
  import sts_pkg::*;
#(
  parameter int TERM_LIMIT = 32,
  parameter int FRAC_BITS  = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sts_stream_if.sink            in_req,
  sts_stream_if.source          out_req,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int MAG_W   = FRAC_BITS + 1;
  localparam int SUM_W   = FRAC_BITS + 2;
  localparam int N_W     = $clog2(TERM_LIMIT + 1);
  localparam int ERR_W   = (FRAC_BITS >= 30) ? FRAC_BITS + 1 : ABS_ERR_W;
  localparam int ERR_SHL = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int ERR_SHR = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam int EXT_W   = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(33'sh1_8000_0000);

  sts_cfg_t cfg;
  logic     adv;

  logic [ERR_W-1:0]     err;
  logic [CNT_SAT_W-1:0] mt_ext;
  logic [CNT_SAT_W-1:0] lim_ext;
  logic [N_W-1:0]       limit;

  sts_ctrl_t       ent_ctrl_r;
  logic [XSQ_W-1:0] ent_xsq_r;
  logic [X_W-1:0]   ax;
  logic [XSQ_W-1:0] xsq_nxt;

  sts_ctrl_t               ch_ctrl [TERM_LIMIT];
  logic [N_W-1:0]          ch_n    [TERM_LIMIT];
  logic [MAG_W-1:0]        ch_mag  [TERM_LIMIT];
  logic signed [SUM_W-1:0] ch_sum  [TERM_LIMIT];
  logic [XSQ_W-1:0]        ch_xsq  [TERM_LIMIT];

  logic                    out_valid_r;
  sts_out_t                out_r;
  sts_out_t                out_nxt;
  logic signed [EXT_W-1:0] sum_ext;
  logic [CNT_SAT_W-1:0]    n_ext;

  sts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the whole chain unless a result is stuck in the output register
  assign adv           = !out_valid_r || out_req.ready;
  assign in_req.ready  = adv;

  // Threshold rescaled to FRAC_BITS, limit clamped to [1, TERM_LIMIT]
  always_comb begin
    err     = (ERR_W'(cfg.abs_error) << ERR_SHL) >> ERR_SHR;
    mt_ext  = CNT_SAT_W'(cfg.max_terms);
    lim_ext = (mt_ext == '0) ? CNT_SAT_W'(1) : mt_ext;
    if (lim_ext > CNT_SAT_W'(TERM_LIMIT)) begin
      lim_ext = CNT_SAT_W'(TERM_LIMIT);
    end
    limit = N_W'(lim_ext);
  end

  // Entry stage: exact x^2 from |x|
  always_comb begin
    ax      = in_req.payload.x_value[X_W-1] ? X_W'(-in_req.payload.x_value)
                                            : X_W'(in_req.payload.x_value);
    xsq_nxt = XSQ_W'(32'(ax) * 32'(ax));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_ctrl_r.valid <= 1'b0;
      ent_ctrl_r.neg   <= 1'b0;
    end else if (adv) begin
      ent_ctrl_r.valid <= in_req.valid;
      ent_ctrl_r.neg   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_xsq_r <= xsq_nxt;
    end
  end

  assign ch_ctrl[0] = ent_ctrl_r;
  assign ch_n[0]    = N_W'(1);
  assign ch_mag[0]  = MAG_W'(1) << FRAC_BITS;
  assign ch_sum[0]  = SUM_W'(1) << FRAC_BITS;
  assign ch_xsq[0]  = ent_xsq_r;

  for (genvar k = 1; k < TERM_LIMIT; k++) begin : g_cell
    sts_cell #(
      .FRAC_BITS  (FRAC_BITS),
      .TERM_LIMIT (TERM_LIMIT),
      .CELL_IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .err_i   (err),
      .limit_i (limit),
      .ctrl_i  (ch_ctrl[k-1]),
      .n_i     (ch_n[k-1]),
      .mag_i   (ch_mag[k-1]),
      .sum_i   (ch_sum[k-1]),
      .xsq_i   (ch_xsq[k-1]),
      .ctrl_o  (ch_ctrl[k]),
      .n_o     (ch_n[k]),
      .mag_o   (ch_mag[k]),
      .sum_o   (ch_sum[k]),
      .xsq_o   (ch_xsq[k])
    );
  end

  // Result: saturate sum and count, flag a term still above threshold
  always_comb begin
    sum_ext = EXT_W'(ch_sum[TERM_LIMIT-1]);
    n_ext   = CNT_SAT_W'(ch_n[TERM_LIMIT-1]);
    if (sum_ext > SAT_HI) begin
      out_nxt.series_sum = SUM_OUT_W'(SAT_HI);
    end else if (sum_ext < SAT_LO) begin
      out_nxt.series_sum = SUM_OUT_W'(SAT_LO);
    end else begin
      out_nxt.series_sum = SUM_OUT_W'(sum_ext);
    end
    out_nxt.terms_used    = (n_ext > CNT_SAT_W'(63)) ? CNT_OUT_W'(63)
                                                     : n_ext[CNT_OUT_W-1:0];
    out_nxt.not_converged = ERR_W'(ch_mag[TERM_LIMIT-1]) > err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_ctrl[TERM_LIMIT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_req.valid   = out_valid_r;
  assign out_req.payload = out_r;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sinc series evaluator: drives random and
// directed arguments over the request channel under several register
// settings, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TERM_LIMIT = 32;
  localparam int FRAC_BITS  = 30;
  localparam int IDLE_LIMIT = 3000;
  localparam int END_WAIT   = 200;
  localparam int PRINT_CAP  = 40;

  // Expected-result store with its own copy of the registers
  class sinc_result_board;
    logic [ABS_ERR_W-1:0] abs_error;
    logic [MAX_TRM_W-1:0] max_terms;
    sts_out_t             pending_results[$];
    int                   errors;

    function new();
      abs_error = ABS_ERROR_RST;
      max_terms = MAX_TERMS_RST;
      errors    = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(sts_reg_t idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        REG_ABS_ERROR: abs_error = data[ABS_ERR_W-1:0];
        REG_MAX_TERMS: max_terms = data[MAX_TRM_W-1:0];
        default: ;
      endcase
    endfunction

    // Series sum at FRAC_BITS = 30: the threshold needs no rescaling
    function sts_out_t predict_sinc(logic signed [X_W-1:0] x);
      longint          xs;
      longint unsigned ax, xsq, mag, lim, n, i, err;
      longint          sum;
      logic            neg;
      sts_out_t        r;
      xs  = x;
      ax  = (xs < 0) ? -xs : xs;
      xsq = ax * ax;
      err = abs_error;
      lim = max_terms;
      if (lim == 0) lim = 1;
      if (lim > TERM_LIMIT) lim = TERM_LIMIT;
      mag = 64'd1 << FRAC_BITS;
      sum = mag;
      n   = 1;
      i   = 2;
      neg = 1'b0;
      while (mag > err && n < lim) begin
        mag = ((mag * xsq) >> XSQ_FRAC) / (i * (i + 1));
        neg = ~neg;
        if (neg) sum -= mag;
        else sum += mag;
        i += 2;
        n++;
      end
      if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
      if (sum < -64'sh80000000) sum = -64'sh80000000;
      r.series_sum    = sum[SUM_OUT_W-1:0];
      r.terms_used    = (n > 63) ? 6'd63 : n[CNT_OUT_W-1:0];
      r.not_converged = (mag > err);
      return r;
    endfunction

    function void note_arg(sts_in_t req);
      pending_results.push_back(predict_sinc(req.x_value));
    endfunction

    task check_result(sts_out_t got);
      sts_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: sum=%h terms=%0d nc=%0b",
                         got.series_sum, got.terms_used, got.not_converged));
        return;
      end
      want = pending_results.pop_front();
      if (got.series_sum !== want.series_sum)
        report($sformatf("series_sum got %h want %h", got.series_sum, want.series_sum));
      if (got.terms_used !== want.terms_used)
        report($sformatf("terms_used got %0d want %0d", got.terms_used, want.terms_used));
      if (got.not_converged !== want.not_converged)
        report($sformatf("not_converged got %0b want %0b",
                         got.not_converged, want.not_converged));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    idle_cycles;

  sts_stream_if #(.payload_t(sts_in_t))  in_if ();
  sts_stream_if #(.payload_t(sts_out_t)) out_if ();

  sinc_result_board board = new();

  sinc_taylor_series #(
    .TERM_LIMIT(TERM_LIMIT),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_if),
    .out_req(out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.note_arg(in_if.payload);
      if (out_if.valid && out_if.ready) board.check_result(out_if.payload);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sinc_taylor_series verification failed");
      $finish;
    end
  end

  // Result-side back pressure
  initial begin
    int run;
    int gap;
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk);
        out_if.ready <= 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
    end
  end

  // Enter and leave at a falling edge; leaves valid high for a following request
  task automatic send_x(logic signed [X_W-1:0] x, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.payload.x_value <= x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold requests until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(sts_reg_t idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.set_reg(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [APB_DATA_W-1:0] err, logic [APB_DATA_W-1:0] terms);
    drain();
    write_reg(REG_ABS_ERROR, err);
    write_reg(REG_MAX_TERMS, terms);
  endtask

  function automatic logic [APB_DATA_W-1:0] pick_abs_error();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom_range(1, 1023);
      3: return 32'd1024;
      4: return 32'h4000_0000;
      5: return 32'h7FFF_FFFF;
      6: return $urandom();
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_max_terms();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(33, 63);
      2: return $urandom();
      default: return $urandom_range(2, 32);
    endcase
  endfunction

  function automatic logic signed [X_W-1:0] pick_x();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh8001;
      3: return X_W'($urandom_range(0, 255) - 128);
      default: return X_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic signed [X_W-1:0] dir_a[8];
    logic signed [X_W-1:0] dir_b[4];
    int                    gap;
    bit                    burst;
    dir_a = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sh8001, 16'sd1, -16'sd1, 16'sh4000, -16'sh4000};
    dir_b = '{16'sh7FFF, 16'sh8000, 16'sd1, 16'sh5555};
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.payload.x_value = '0;
    out_if.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    idle_cycles           = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the registers
    foreach (dir_a[k]) send_x(dir_a[k], 0);
    // Zero threshold with a limit above the chain length
    configure(32'd0, 32'd63);
    foreach (dir_b[k]) send_x(dir_b[k], 0);
    // Largest threshold, zero limit acts as one term
    configure(32'h7FFF_FFFF, 32'd0);
    send_x(16'sh7FFF, 0);
    send_x(-16'sd1, 0);
    configure(32'd1, 32'd32);
    send_x(16'sh7FFF, 0);
    send_x(16'sh8000, 0);
    send_x(16'sd12345, 0);
    configure(32'd1, 32'd1);
    send_x(16'sh7FFF, 0);
    configure(32'hFFFF_FFFF, 32'd33);
    send_x(16'sh8000, 0);

    for (int p = 0; p < 8; p++) begin
      configure(pick_abs_error(), pick_max_terms());
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 49) == 0) drain();
        gap = burst ? 0 : pick_gap();
        send_x(pick_x(), gap);
      end
    end

    drain();
    repeat (END_WAIT) @(negedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    if (board.errors == 0) begin
      $display("sinc_taylor_series verification clean");
    end else begin
      $display("sinc_taylor_series verification failed");
    end
    $finish;
  end

endmodule
